// File: rtl/crg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crg_pkg: shared types and constants for the camera ray generator
// Fixed-point widths, register codes and the stage records of the pipeline.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int CB   = 20;            // vector component width, Q8.12
  localparam int UVB  = 16;            // fraction bits of u, v
  localparam int UW   = UVB + 1;       // u, v port width
  localparam int FB   = 12;            // fraction bits of position data
  localparam int DF   = CB - 2;        // fraction bits of the direction
  localparam int AW   = 6;             // APB address width (8-byte registers)
  localparam int DW   = 64;            // APB data width
  localparam int VW   = 3 * CB;        // packed vector register width
  localparam int PW   = 2 * CB + 1;    // config product width
  localparam int MW   = 43;            // direction magnitude before scaling
  localparam int NW   = 30;            // direction magnitude after scaling
  localparam int SW   = 2 * NW + 2;    // sum of squares width
  localparam int RW   = NW + 1;        // square root width
  localparam int QW   = DF + 1;        // quotient width
  localparam int DVW  = NW + DF + 1;   // dividend width
  localparam int KW   = $clog2(MW - NW + 1);
  localparam int HALF_UV = 1 << (UVB - 1);
  localparam int DLIM    = 1 << DF;

  typedef enum logic [2:0] {
    REG_POS   = 3'd0,
    REG_RIGHT = 3'd1,
    REG_UP    = 3'd2,
    REG_FWD   = 3'd3,
    REG_APW   = 3'd4,
    REG_APH   = 3'd5,
    REG_DEPTH = 3'd6
  } reg_idx_t;

  typedef logic signed [CB-1:0] comp_t;

  // data that rides along with every item once the origin is known
  typedef struct packed {
    logic [2:0][CB-1:0] org;
    logic [2:0][CB-1:0] odir;
    logic               persp;
    logic [2:0]         neg;
  } side_t;

  typedef struct packed {
    side_t              sd;
    logic [2:0][NW-1:0] mag;
    logic [SW-1:0]      rem;
    logic [RW-1:0]      root;
  } sq_t;

  typedef struct packed {
    side_t               sd;
    logic [RW-1:0]       len;
    logic [2:0][DVW-1:0] rem;
    logic [2:0][QW-1:0]  q;
  } dv_t;

  function automatic comp_t comp_of(input logic [VW-1:0] v, input int unsigned i);
    return v[i*CB +: CB];
  endfunction

endpackage

// File: rtl/camera_ray_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_generator_top: pinhole / orthographic ray generator
// Maps a screen coordinate (u,v) to a ray origin on the viewport and a unit
// direction, from a camera frame held in APB registers.
// ----------------------------------------------------------------------------
// Pipeline: 8 front stages, 31 square-root stages, 19 divide stages and
//   the output register lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle unless stalled; set by the one-bit-per-stage
//   sqrt and divide pipelines, which accept a new item every unstalled cycle.
// Back-pressure stalls every stage together; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and restores the
//   camera registers to their reset values (aperture 1.0, the rest zero).
module camera_ray_generator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [crg_pkg::UW-1:0]      in_u_coord,
  input  logic [crg_pkg::UW-1:0]      in_v_coord,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [crg_pkg::CB-1:0] out_origin_x,
  output logic signed [crg_pkg::CB-1:0] out_origin_y,
  output logic signed [crg_pkg::CB-1:0] out_origin_z,
  output logic signed [crg_pkg::CB-1:0] out_dir_x,
  output logic signed [crg_pkg::CB-1:0] out_dir_y,
  output logic signed [crg_pkg::CB-1:0] out_dir_z,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crg_pkg::AW-1:0]      paddr,
  input  logic [crg_pkg::DW-1:0]      pwdata,
  output logic [crg_pkg::DW-1:0]      prdata,
  output logic                        pready
);
  import crg_pkg::*;

  localparam int TW   = 61;               // origin accumulator width
  localparam int OSH  = FB + UVB;         // origin rounding shift
  localparam int OSW  = CB + DF - FB;     // orthographic scaled width
  localparam int OMAX = (1 << (CB - 1)) - 1;
  localparam int OMIN = -(1 << (CB - 1));

  // --------------------------------------------------------------------------
  // Camera registers. Writes land in the APB access phase; pready is tied
  // high so every access completes without wait states.
  // --------------------------------------------------------------------------
  logic [VW-1:0]        pos_r, right_r, up_r, fwd_r;
  logic [CB-1:0]        apw_r, aph_r;
  logic signed [CB-1:0] depth_r;
  reg_idx_t             ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      right_r <= '0;
      up_r    <= '0;
      fwd_r   <= '0;
      apw_r   <= CB'(1 << FB);
      aph_r   <= CB'(1 << FB);
      depth_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_POS:   pos_r   <= pwdata[VW-1:0];
        REG_RIGHT: right_r <= pwdata[VW-1:0];
        REG_UP:    up_r    <= pwdata[VW-1:0];
        REG_FWD:   fwd_r   <= pwdata[VW-1:0];
        REG_APW:   apw_r   <= pwdata[CB-1:0];
        REG_APH:   aph_r   <= pwdata[CB-1:0];
        REG_DEPTH: depth_r <= pwdata[CB-1:0];
        default: ;   // unmapped address: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_POS:   prdata = DW'(pos_r);
      REG_RIGHT: prdata = DW'(right_r);
      REG_UP:    prdata = DW'(up_r);
      REG_FWD:   prdata = DW'(fwd_r);
      REG_APW:   prdata = DW'(apw_r);
      REG_APH:   prdata = DW'(aph_r);
      REG_DEPTH: prdata = DW'(depth_r);
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: one enable for the whole pipe. It moves whenever the
  // output register is empty or being drained this cycle.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic [7:0]    fv_r;      // valid bits of front stages 1..8
  logic [RW-1:0] sqv_r;     // valid bits of the sqrt stages
  logic [QW-1:0] dvv_r;     // valid bits of the divide stages

  // --------------------------------------------------------------------------
  // Stage 1: center u,v on the viewport and form the frame products.
  // origin*2^28 = pos*2^28 + (right*w)*(u-1/2) + (up*h)*(1/2-v)
  // --------------------------------------------------------------------------
  logic signed [UW:0]     du1_r, dv1_r;
  logic signed [PW-1:0]   rw1_r [3];
  logic signed [PW-1:0]   uh1_r [3];
  logic signed [2*CB-1:0] fd1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      du1_r <= $signed({1'b0, in_u_coord}) - $signed((UW+1)'(HALF_UV));
      dv1_r <= $signed((UW+1)'(HALF_UV)) - $signed({1'b0, in_v_coord});
      for (int i = 0; i < 3; i++) begin
        rw1_r[i] <= comp_of(right_r, i) * $signed({1'b0, apw_r});
        uh1_r[i] <= comp_of(up_r, i) * $signed({1'b0, aph_r});
        fd1_r[i] <= comp_of(fwd_r, i) * depth_r;
      end
    end
  end

  // Stage 2: scale the edge vectors by the centered coordinates
  logic signed [PW+UW:0]  a2_r [3];
  logic signed [PW+UW:0]  b2_r [3];
  logic signed [2*CB-1:0] fd2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a2_r[i]  <= rw1_r[i] * du1_r;
        b2_r[i]  <= uh1_r[i] * dv1_r;
        fd2_r[i] <= fd1_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum, round half up, saturate -> origin. Focal point and the
  // orthographic direction are formed here as well.
  // --------------------------------------------------------------------------
  side_t                sd3_nxt, sd3_r;
  logic signed [MW-1:0] focal3_r [3];
  logic signed [MW-1:0] focal3_nxt [3];

  always_comb begin
    logic signed [TW-1:0]  t;
    logic signed [TW-1:0]  tr;
    logic signed [OSW-1:0] os;
    sd3_nxt       = '0;
    sd3_nxt.persp = (depth_r > 0);
    for (int i = 0; i < 3; i++) begin
      t  = (TW'(comp_of(pos_r, i)) <<< OSH) + TW'(a2_r[i]) + TW'(b2_r[i]);
      tr = (t + (TW'(1) <<< (OSH - 1))) >>> OSH;
      if (tr > OMAX)      sd3_nxt.org[i] = CB'(OMAX);
      else if (tr < OMIN) sd3_nxt.org[i] = CB'(OMIN);
      else                sd3_nxt.org[i] = tr[CB-1:0];
      os = OSW'(comp_of(fwd_r, i)) <<< (DF - FB);
      if (os > DLIM)       sd3_nxt.odir[i] = CB'(DLIM);
      else if (os < -DLIM) sd3_nxt.odir[i] = CB'(-DLIM);
      else                 sd3_nxt.odir[i] = os[CB-1:0];
      focal3_nxt[i] = (MW'(comp_of(pos_r, i)) <<< FB) - MW'(fd2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r <= sd3_nxt;
      for (int i = 0; i < 3; i++) focal3_r[i] <= focal3_nxt[i];
    end
  end

  // Stage 4: direction vector origin - focal (Q.24), split into sign and size
  side_t         sd4_r, sd4_nxt;
  logic [MW-1:0] mag4_r [3];
  logic [MW-1:0] mag4_nxt [3];

  always_comb begin
    logic signed [MW-1:0] d;
    sd4_nxt = sd3_r;
    for (int i = 0; i < 3; i++) begin
      d = (MW'($signed(sd3_r.org[i])) <<< FB) - focal3_r[i];
      sd4_nxt.neg[i] = d[MW-1];
      mag4_nxt[i]    = d[MW-1] ? MW'(-d) : MW'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r <= sd4_nxt;
      for (int i = 0; i < 3; i++) mag4_r[i] <= mag4_nxt[i];
    end
  end

  // Stage 5: common right shift that brings all magnitudes below 2^30
  side_t         sd5_r;
  logic [MW-1:0] mag5_r [3];
  logic [KW-1:0] k5_r;
  logic [KW-1:0] k5_nxt;

  always_comb begin
    logic [MW-1:0] mx;
    mx = mag4_r[0];
    if (mag4_r[1] > mx) mx = mag4_r[1];
    if (mag4_r[2] > mx) mx = mag4_r[2];
    k5_nxt = '0;
    for (int kk = 1; kk <= MW - NW; kk++) begin
      if ((mx >> (NW - 1 + kk)) != '0) k5_nxt = KW'(kk);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r <= sd4_r;
      k5_r  <= k5_nxt;
      for (int i = 0; i < 3; i++) mag5_r[i] <= mag4_r[i];
    end
  end

  // Stage 6: apply the shift
  side_t         sd6_r;
  logic [NW-1:0] mag6_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sd6_r <= sd5_r;
      for (int i = 0; i < 3; i++) mag6_r[i] <= NW'(mag5_r[i] >> k5_r);
    end
  end

  // Stage 7: squares
  side_t           sd7_r;
  logic [NW-1:0]   mag7_r [3];
  logic [2*NW-1:0] sq7_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sd7_r <= sd6_r;
      for (int i = 0; i < 3; i++) begin
        mag7_r[i] <= mag6_r[i];
        sq7_r[i]  <= mag6_r[i] * mag6_r[i];
      end
    end
  end

  // Stage 8: sum of squares
  sq_t s8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_r.sd   <= sd7_r;
      s8_r.root <= '0;
      s8_r.rem  <= SW'(sq7_r[0]) + SW'(sq7_r[1]) + SW'(sq7_r[2]);
      for (int i = 0; i < 3; i++) s8_r.mag[i] <= mag7_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one result bit per stage, MSB first. rem holds
  // sum - root^2 throughout.
  // --------------------------------------------------------------------------
  sq_t sq_r [RW];

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    localparam int J = RW - 1 - g;
    sq_t src, sq_nxt;
    if (g == 0) begin : g_first
      assign src = s8_r;
    end else begin : g_next
      assign src = sq_r[g-1];
    end
    always_comb begin
      logic [SW-1:0] trial;
      trial  = (SW'(src.root) << (J + 1)) | (SW'(1) << (2 * J));
      sq_nxt = src;
      if (src.rem >= trial) begin
        sq_nxt.rem  = src.rem - trial;
        sq_nxt.root = src.root | (RW'(1) << J);
      end
    end
    always_ff @(posedge clk) begin
      if (en) sq_r[g] <= sq_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divide: q = round(mag * 2^18 / len), one quotient bit per stage for all
  // three lanes. The dividend is below len * 2^19, so 19 steps suffice.
  // --------------------------------------------------------------------------
  dv_t dv_r [QW];
  dv_t d0;

  always_comb begin
    d0     = '0;
    d0.sd  = sq_r[RW-1].sd;
    d0.len = sq_r[RW-1].root;
    for (int i = 0; i < 3; i++) begin
      d0.rem[i] = (DVW'(sq_r[RW-1].mag[i]) << DF) + DVW'(sq_r[RW-1].root >> 1);
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int J = QW - 1 - g;
    dv_t src, dv_nxt;
    if (g == 0) begin : g_first
      assign src = d0;
    end else begin : g_next
      assign src = dv_r[g-1];
    end
    always_comb begin
      logic [DVW-1:0] dsr;
      dsr    = DVW'(src.len) << J;
      dv_nxt = src;
      for (int i = 0; i < 3; i++) begin
        if (src.rem[i] >= dsr) begin
          dv_nxt.rem[i]  = src.rem[i] - dsr;
          dv_nxt.q[i][J] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[g] <= dv_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick orthographic or normalized direction, apply sign.
  // In perspective mode a zero-length direction gives a zero vector.
  // --------------------------------------------------------------------------
  comp_t org_o_r [3];
  comp_t dir_o_r [3];
  comp_t dir_o_nxt [3];

  always_comb begin
    logic [QW-1:0] qs;
    comp_t         qe;
    for (int i = 0; i < 3; i++) begin
      qs = (dv_r[QW-1].q[i] > QW'(DLIM)) ? QW'(DLIM) : dv_r[QW-1].q[i];
      qe = CB'(qs);
      if (!dv_r[QW-1].sd.persp)   dir_o_nxt[i] = dv_r[QW-1].sd.odir[i];
      else if (dv_r[QW-1].len == '0) dir_o_nxt[i] = '0;
      else if (dv_r[QW-1].sd.neg[i]) dir_o_nxt[i] = -qe;
      else                           dir_o_nxt[i] = qe;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        org_o_r[i] <= dv_r[QW-1].sd.org[i];
        dir_o_r[i] <= dir_o_nxt[i];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      sqv_r       <= '0;
      dvv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fv_r        <= {fv_r[6:0], in_valid};
      sqv_r       <= {sqv_r[RW-2:0], fv_r[7]};
      dvv_r       <= {dvv_r[QW-2:0], sqv_r[RW-1]};
      out_valid_r <= dvv_r[QW-1];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_origin_x = org_o_r[0];
  assign out_origin_y = org_o_r[1];
  assign out_origin_z = org_o_r[2];
  assign out_dir_x    = dir_o_r[0];
  assign out_dir_y    = dir_o_r[1];
  assign out_dir_z    = dir_o_r[2];

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // square root is floor: remainder never exceeds 2*root
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sqv_r[RW-1] |-> (sq_r[RW-1].rem <= (SW'(sq_r[RW-1].root) << 1)))
    else $error("sqrt remainder out of range");

  // divider leaves a remainder below the divisor on a live length
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dvv_r[QW-1] && dv_r[QW-1].sd.persp && dv_r[QW-1].len != '0) |->
      (dv_r[QW-1].rem[0] < DVW'(dv_r[QW-1].len) &&
       dv_r[QW-1].rem[1] < DVW'(dv_r[QW-1].len) &&
       dv_r[QW-1].rem[2] < DVW'(dv_r[QW-1].len)))
    else $error("divide remainder not below divisor");

  // direction components stay within the unit range
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dir_x <= DLIM && out_dir_x >= -DLIM &&
                     out_dir_y <= DLIM && out_dir_y >= -DLIM &&
                     out_dir_z <= DLIM && out_dir_z >= -DLIM))
    else $error("direction component out of range");

  // the pipe stalls only while a valid output beat is blocked
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("pipe stalled without a blocked output beat");

endmodule

// File: bench/crg_ray_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crg_ray_checker: ray predictor and scoreboard for the camera ray generator
// Watches the input and result channels, computes the expected ray for each
// accepted (u,v) beat from a private copy of the camera registers, and
// compares every result beat with the oldest expected ray.
// ----------------------------------------------------------------------------
module crg_ray_checker
  import crg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [UW-1:0]       in_u_coord,
  input  logic [UW-1:0]       in_v_coord,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [CB-1:0] out_origin_x,
  input  logic signed [CB-1:0] out_origin_y,
  input  logic signed [CB-1:0] out_origin_z,
  input  logic signed [CB-1:0] out_dir_x,
  input  logic signed [CB-1:0] out_dir_y,
  input  logic signed [CB-1:0] out_dir_z,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AW-1:0]       paddr,
  input  logic [DW-1:0]       pwdata,
  output int                  fail_count,
  output int                  rays_pending
);

  typedef struct {
    logic signed [CB-1:0] org [3];
    logic signed [CB-1:0] dir [3];
  } ray_t;

  logic [VW-1:0] cam_vec [4];
  logic [CB-1:0] ap_w, ap_h;
  logic [CB-1:0] depth_reg;
  ray_t          ray_q [$];

  function automatic longint vcomp(input logic [VW-1:0] r, input int i);
    logic signed [CB-1:0] c;
    c = r[i*CB +: CB];
    return longint'(c);
  endfunction

  // round half up of x / 2^s
  function automatic longint rnd_shift(input longint x, input int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic ray_t predict_ray(input longint u, input longint v);
    ray_t rr;
    longint omax, dlim, p, rt, up, f, p1, t, o, dv [3], dpt, s;
    longint unsigned mag [3], mx, sum, len, q;
    int k;
    omax = (longint'(1) << (CB - 1)) - 1;
    dlim = longint'(1) << DF;
    dpt  = longint'($signed(depth_reg));
    mx   = 0;
    sum  = 0;
    for (int i = 0; i < 3; i++) begin
      p  = vcomp(cam_vec[2'(REG_POS)], i);
      rt = vcomp(cam_vec[2'(REG_RIGHT)], i);
      up = vcomp(cam_vec[2'(REG_UP)], i);
      p1 = p * (longint'(1) << (FB + 1)) - rt * longint'(ap_w) + up * longint'(ap_h);
      t  = p1 * (longint'(1) << (UVB - 1)) + rt * longint'(ap_w) * u
           - up * longint'(ap_h) * v;
      o  = rnd_shift(t, FB + UVB);
      if (o > omax) o = omax;
      if (o < -omax - 1) o = -omax - 1;
      rr.org[i] = o[CB-1:0];
    end
    if (dpt <= 0) begin
      for (int i = 0; i < 3; i++) begin
        s = vcomp(cam_vec[2'(REG_FWD)], i) * (longint'(1) << (DF - FB));
        if (s > dlim) s = dlim;
        if (s < -dlim) s = -dlim;
        rr.dir[i] = s[CB-1:0];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        p = vcomp(cam_vec[2'(REG_POS)], i);
        f = vcomp(cam_vec[2'(REG_FWD)], i);
        dv[i] = longint'(rr.org[i]) * (longint'(1) << FB)
                - (p * (longint'(1) << FB) - f * dpt);
        mag[i] = dv[i] < 0 ? longint'(-dv[i]) : longint'(dv[i]);
        if (mag[i] > mx) mx = mag[i];
      end
      k = 0;
      while ((mx >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 3; i++) begin
        mag[i] >>= k;
        sum += mag[i] * mag[i];
      end
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          rr.dir[i] = '0;
        end else begin
          q = ((mag[i] << DF) + len / 2) / len;
          if (q > longint'(dlim)) q = dlim;
          s = dv[i] < 0 ? -longint'(q) : longint'(q);
          rr.dir[i] = s[CB-1:0];
        end
      end
    end
    return rr;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ray mismatch on %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count   = 0;
    rays_pending = 0;
  end

  always @(posedge clk) begin
    ray_t want;
    logic signed [CB-1:0] got [6];
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cam_vec[i] <= '0;
      ap_w      <= 20'd4096;
      ap_h      <= 20'd4096;
      depth_reg <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AW-1:3]) inside
          REG_POS, REG_RIGHT, REG_UP, REG_FWD: cam_vec[paddr[AW-2:3]] <= pwdata[VW-1:0];
          REG_APW:   ap_w      <= pwdata[CB-1:0];
          REG_APH:   ap_h      <= pwdata[CB-1:0];
          REG_DEPTH: depth_reg <= pwdata[CB-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        ray_q.push_back(predict_ray(longint'(in_u_coord), longint'(in_v_coord)));
      if (out_valid && out_ready) begin
        if (ray_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          want = ray_q.pop_front();
          got = '{out_origin_x, out_origin_y, out_origin_z, out_dir_x, out_dir_y, out_dir_z};
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== want.org[i])
              report_mismatch($sformatf("origin[%0d]", i), got[i], want.org[i]);
            if (got[3+i] !== want.dir[i])
              report_mismatch($sformatf("dir[%0d]", i), got[3+i], want.dir[i]);
          end
        end
      end
      rays_pending <= ray_q.size();
    end
  end

endmodule

// File: bench/camera_ray_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_generator_top_tb: stimulus and verdict for the ray generator
// Programs camera setups over APB, streams (u,v) beats under three idling
// mixes and lets the checker compare every ray against its prediction.
// ----------------------------------------------------------------------------
module camera_ray_generator_top_tb;
  import crg_pkg::*;

  localparam int LATENCY   = 59;
  localparam int WDOG_MAX  = 20000;  // cycles with no beat on either side and no APB access

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [UW-1:0] in_u_coord = '0, in_v_coord = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [CB-1:0] out_origin_x, out_origin_y, out_origin_z;
  logic signed [CB-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0, prdata;
  logic pready;
  int fail_count, rays_pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  camera_ray_generator_top dut (.*);

  crg_ray_checker chk (.*);

  // receiver: ready toggles at random according to the current idle mix
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog: counts cycles without any accepted beat or APB access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("camera_ray_generator_top: mismatch");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(idx) << 3;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sends one beat; optional random idle cycles first
  task automatic send_uv(input logic [UW-1:0] u, input logic [UW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_u_coord <= u;
    in_v_coord <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rays_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [19:0] comp_rand(input bit unit_ish);
    if (unit_ish) return 20'($signed($urandom_range(8192)) - 4096);
    return 20'($urandom);
  endfunction

  function automatic logic [DW-1:0] vec_rand(input bit unit_ish);
    return {4'd0, comp_rand(unit_ish), comp_rand(unit_ish), comp_rand(unit_ish)};
  endfunction

  // uv mostly inside [0,1], sometimes anywhere in the 17-bit range
  function automatic logic [UW-1:0] uv_rand();
    if ($urandom_range(9) == 0) return UW'($urandom);
    return UW'($urandom_range(65536));
  endfunction

  task automatic random_camera(input bit wild);
    apb_write(REG_POS,   vec_rand(!wild));
    apb_write(REG_RIGHT, vec_rand(!wild));
    apb_write(REG_UP,    vec_rand(!wild));
    apb_write(REG_FWD,   vec_rand(!wild));
    apb_write(REG_APW,   wild ? 64'($urandom) & 64'hFFFFF : 64'($urandom_range(16384)));
    apb_write(REG_APH,   wild ? 64'($urandom) & 64'hFFFFF : 64'($urandom_range(16384)));
    case ($urandom_range(3))
      0: apb_write(REG_DEPTH, 64'd0);
      1: apb_write(REG_DEPTH, 64'(20'($signed(-$urandom_range(524288)))));
      default: apb_write(REG_DEPTH, wild ? 64'($urandom) & 64'hFFFFF
                                         : 64'($urandom_range(40000, 1)));
    endcase
  endtask

  localparam logic [UW-1:0] UV_ONE = 17'd65536;
  localparam logic [UW-1:0] UV_MAX = 17'h1FFFF;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset camera (all zero vectors, orthographic, zero direction)
    send_uv('0, '0);
    send_uv(UV_ONE, UV_ONE);
    drain();

    // unit camera, perspective
    apb_write(REG_POS,   {4'd0, 20'd0, 20'd0, 20'd0});
    apb_write(REG_RIGHT, {4'd0, 20'd0, 20'd0, 20'd4096});
    apb_write(REG_UP,    {4'd0, 20'd0, 20'd4096, 20'd0});
    apb_write(REG_FWD,   {4'd0, 20'd4096, 20'd0, 20'd0});
    apb_write(REG_APW,   64'd8192);
    apb_write(REG_APH,   64'd8192);
    apb_write(REG_DEPTH, 64'd4096);
    send_uv('0, '0);
    send_uv(UV_ONE, '0);
    send_uv('0, UV_ONE);
    send_uv(17'd32768, 17'd32768);
    send_uv(UV_MAX, UV_MAX);
    send_uv(17'h15555, 17'h0AAAA);
    drain();

    // extremes: saturating origin, negative depth (orthographic), large forward
    apb_write(REG_POS,   {4'd0, 20'h7FFFF, 20'h80000, 20'h7FFFF});
    apb_write(REG_RIGHT, {4'd0, 20'h80000, 20'h7FFFF, 20'h80000});
    apb_write(REG_UP,    {4'd0, 20'h7FFFF, 20'h7FFFF, 20'h80000});
    apb_write(REG_FWD,   {4'd0, 20'h80000, 20'h7FFFF, 20'h00001});
    apb_write(REG_APW,   64'hFFFFF);
    apb_write(REG_APH,   64'hFFFFF);
    apb_write(REG_DEPTH, 64'h80000);
    send_uv('0, UV_MAX);
    send_uv(UV_MAX, '0);
    send_uv(UV_ONE, UV_ONE);
    drain();

    // max positive depth, same wild frame: huge perspective magnitudes
    apb_write(REG_DEPTH, 64'h7FFFF);
    send_uv('0, '0);
    send_uv(UV_MAX, UV_MAX);
    send_uv(17'd12345, 17'd54321);
    drain();

    // perspective with zero direction: origin equals focal point
    apb_write(REG_POS,   64'd0);
    apb_write(REG_RIGHT, 64'd0);
    apb_write(REG_UP,    64'd0);
    apb_write(REG_FWD,   64'd0);
    apb_write(REG_DEPTH, 64'd4096);
    send_uv(17'd100, 17'd200);
    drain();

    // random phases: three idle mixes, fresh camera every 52 beats
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 15 : 0;
      for (int blk = 0; blk < 10; blk++) begin
        random_camera(blk % 4 == 3);
        for (int n = 0; n < 52; n++) send_uv(uv_rand(), uv_rand());
        drain();
      end
    end

    in_valid <= 1'b0;
    while (rays_pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("camera_ray_generator_top: match");
    else
      $display("camera_ray_generator_top: mismatch");
    $finish;
  end

endmodule

// File: camera_ray_generator_top.f
rtl/crg_pkg.sv
rtl/camera_ray_generator_top.sv
bench/crg_ray_checker.sv
bench/camera_ray_generator_top_tb.sv
